// ===== hw/rtl/u16u8_pkg.sv =====
// u16u8_pkg: shared types and constants of the utf-16le to utf-8 transcoder
// depends on nothing; imported by every module of the block

package u16u8_pkg;

	localparam int unsigned BUDGET_W = 27;
	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 27'h4000000;

	// code point of a joined surrogate pair is this base plus 20 payload bits
	localparam int unsigned CP_W = 21;
	localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h10000;

	// top six bits of a high and of a low surrogate unit
	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	localparam logic [7:0] LEAD1_MASK = 8'h00;
	localparam logic [7:0] LEAD2_MASK = 8'hc0;
	localparam logic [7:0] LEAD3_MASK = 8'he0;
	localparam logic [7:0] LEAD4_MASK = 8'hf0;
	localparam logic [7:0] CONT_MASK  = 8'h80;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_BUDGET    = 2'd2
	} status_t;

	// everything one input word produces: up to four utf-8 bytes and a status
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      nbytes;
		logic            stat_v;
		status_t         stat;
	} results_t;

endpackage

// ===== hw/rtl/utf16le_to_utf8_transcoder_top.sv =====
// utf16le_to_utf8_transcoder_top: stream ports, budget register, assertions
// depends on u16u8_pkg, u16u8_dec and u16u8_seq
//
// usage
//   s_axis carries one utf-16le byte per word, low byte of each unit first;
//   tlast marks the final byte of a string. m_axis carries one result per word:
//   either a utf-8 byte or, after the last input byte of a string, its status
//   (ok, malformed, budget exceeded). m_axis tlast flags the final result that
//   one input word caused.
//   cfg writes the output byte budget per string; write it only while idle.
// timing
//   an input word is decoded in the cycle it is accepted into a result list
//   of up to five entries; its first result goes from the list register to
//   the output register and so onto m_axis. the sequencer sends one result
//   per cycle while m_axis is not stalled; a unit outside the surrogate range
//   causes up to three bytes, a completed surrogate pair four. a new word is
//   taken in the same cycle the last result of the previous list moves out.
// reset and stall
//   arst_n clears all string state, empties the result list and the output
//   register and restores the budget to 2^26 bytes. a stalled m_axis holds
//   its word; the list waits behind it and s_axis tready drops until the
//   list can drain.

module utf16le_to_utf8_transcoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // string_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic [3:0]  m_axis_tuser,   // [0] byte_valid, [1] status_valid, [3:2] status
	output logic        m_axis_tlast,   // run_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [26:0] cfg_data        // output_budget
);
	import u16u8_pkg::*;

	logic [BUDGET_W-1:0] budget_q;
	results_t            res;
	logic                in_accept;
	logic [1:0]          status;

	// the budget register takes a write in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			budget_q <= BUDGET_RESET;
		else if (cfg_valid)
			budget_q <= cfg_data;
	end

	assign in_accept = s_axis_tvalid && s_axis_tready;

	// decode: string state plus the utf-8 encoding of the current unit
	u16u8_dec u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.data_byte  (s_axis_tdata),
		.string_end (s_axis_tlast),
		.budget     (budget_q),
		.res        (res)
	);

	// result list register and output register
	u16u8_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.res          (res),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_byte     (m_axis_tdata),
		.byte_valid   (m_axis_tuser[0]),
		.status_valid (m_axis_tuser[1]),
		.status       (status),
		.run_last     (m_axis_tlast)
	);

	assign m_axis_tuser[3:2] = status;

	// a status word always closes the run of its input word
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("status word without tlast");

	// every word is exactly one of byte or status
	a_kind_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] ^ m_axis_tuser[1]))
		else $error("output word kind not one-hot");

	// byte words carry ok status, status words carry a zero byte
	a_field_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] ? (m_axis_tuser[3:2] == ST_OK)
		                                   : (m_axis_tdata == 8'h00)))
		else $error("unused output field not zero");

	// the input side is never ready while the output is stalled with a full list
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready && $past(m_axis_tvalid && !m_axis_tready)
		&& $past(!s_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while result list is blocked");

endmodule

// ===== hw/rtl/u16u8_dec.sv =====
// u16u8_dec: per-string state and single-pass decode of one input byte
// depends on u16u8_pkg; feeds the result list to u16u8_seq

module u16u8_dec (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [7:0]                       data_byte,
	input  logic                             string_end,
	input  logic [u16u8_pkg::BUDGET_W-1:0]   budget,
	output u16u8_pkg::results_t              res
);
	import u16u8_pkg::*;

	logic [7:0]          hold_q, hold_d;
	logic                odd_q, odd_d;
	logic [9:0]          hsb_q, hsb_d;
	logic                pend_q, pend_d;
	logic [BUDGET_W-1:0] prod_q, prod_d;
	status_t             err_q, err_d;

	logic [15:0]         unit;
	logic                is_high, is_low;
	logic                emit;
	logic [CP_W-1:0]     cp;
	logic [2:0]          width;
	logic [BUDGET_W-1:0] remaining;
	logic                refuse;
	logic [3:0][7:0]     enc;

	assign unit    = {data_byte, hold_q};
	assign is_high = (unit[15:10] == HIGH_SURR_TAG);
	assign is_low  = (unit[15:10] == LOW_SURR_TAG);

	// code unit assembly and surrogate pairing
	always_comb begin
		emit = 1'b0;
		cp   = '0;
		if (odd_q && err_q == ST_OK) begin
			if (pend_q) begin
				if (is_low) begin
					emit = 1'b1;
					cp   = CP_SUPP_BASE + {1'b0, hsb_q, unit[9:0]};
				end
			end else if (!is_high && !is_low) begin
				emit = 1'b1;
				cp   = {{(CP_W-16){1'b0}}, unit};
			end
		end
	end

	always_comb begin
		if (cp[CP_W-1:7] == '0)
			width = 3'd1;
		else if (cp[CP_W-1:11] == '0)
			width = 3'd2;
		else if (cp[CP_W-1:16] == '0)
			width = 3'd3;
		else
			width = 3'd4;
	end

	assign remaining = budget - prod_q;
	assign refuse    = (prod_q > budget) || ({{(BUDGET_W-3){1'b0}}, width} > remaining);

	always_comb begin
		enc = '0;
		unique case (width)
			3'd1: begin
				enc[0] = LEAD1_MASK | {1'b0, cp[6:0]};
			end
			3'd2: begin
				enc[0] = LEAD2_MASK | {3'b000, cp[10:6]};
				enc[1] = CONT_MASK | {2'b00, cp[5:0]};
			end
			3'd3: begin
				enc[0] = LEAD3_MASK | {4'b0000, cp[15:12]};
				enc[1] = CONT_MASK | {2'b00, cp[11:6]};
				enc[2] = CONT_MASK | {2'b00, cp[5:0]};
			end
			default: begin
				enc[0] = LEAD4_MASK | {5'b00000, cp[20:18]};
				enc[1] = CONT_MASK | {2'b00, cp[17:12]};
				enc[2] = CONT_MASK | {2'b00, cp[11:6]};
				enc[3] = CONT_MASK | {2'b00, cp[5:0]};
			end
		endcase
	end

	// next string state and the result list
	always_comb begin
		hold_d     = hold_q;
		odd_d      = odd_q;
		hsb_d      = hsb_q;
		pend_d     = pend_q;
		prod_d     = prod_q;
		err_d      = err_q;
		res.bytes  = enc;
		res.nbytes = 3'd0;
		res.stat_v = string_end;
		res.stat   = ST_OK;

		if (!odd_q) begin
			hold_d = data_byte;
			odd_d  = 1'b1;
		end else begin
			odd_d = 1'b0;
			if (err_q == ST_OK) begin
				if (pend_q) begin
					pend_d = 1'b0;
					if (!is_low)
						err_d = ST_MALFORMED;
				end else if (is_high) begin
					hsb_d  = unit[9:0];
					pend_d = 1'b1;
				end else if (is_low) begin
					err_d = ST_MALFORMED;
				end
			end
		end

		if (emit) begin
			if (refuse) begin
				err_d = ST_BUDGET;
			end else begin
				res.nbytes = width;
				prod_d     = prod_q + {{(BUDGET_W-3){1'b0}}, width};
			end
		end

		// odd length wins over everything, a dangling high surrogate only over ok
		if (odd_d)
			res.stat = ST_MALFORMED;
		else if (err_d == ST_OK && pend_d)
			res.stat = ST_MALFORMED;
		else
			res.stat = err_d;

		if (string_end) begin
			hold_d = '0;
			odd_d  = 1'b0;
			hsb_d  = '0;
			pend_d = 1'b0;
			prod_d = '0;
			err_d  = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			odd_q  <= 1'b0;
			hsb_q  <= '0;
			pend_q <= 1'b0;
			prod_q <= '0;
			err_q  <= ST_OK;
		end else if (accept) begin
			hold_q <= hold_d;
			odd_q  <= odd_d;
			hsb_q  <= hsb_d;
			pend_q <= pend_d;
			prod_q <= prod_d;
			err_q  <= err_d;
		end
	end

endmodule

// ===== hw/rtl/u16u8_seq.sv =====
// u16u8_seq: holds one word's result list, sends one per cycle while not stalled
// depends on u16u8_pkg; driven by u16u8_dec

module u16u8_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  u16u8_pkg::results_t res,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                byte_valid,
	output logic                status_valid,
	output logic [1:0]          status,
	output logic                run_last
);
	import u16u8_pkg::*;

	results_t   list_s1;
	logic       list_valid_s1;
	logic [2:0] idx_q;
	logic [2:0] total;
	logic       out_free, is_last, step, load;
	logic       sel_byte;

	assign total    = list_s1.nbytes + {2'b00, list_s1.stat_v};
	assign out_free = !out_valid || out_ready;
	assign is_last  = (idx_q == total - 3'd1);
	assign step     = list_valid_s1 && out_free;
	assign in_ready = !list_valid_s1 || (step && is_last);
	assign load     = in_valid && in_ready && ((res.nbytes != 3'd0) || res.stat_v);
	assign sel_byte = (idx_q < list_s1.nbytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_valid_s1 <= 1'b0;
			idx_q         <= '0;
		end else if (load) begin
			list_valid_s1 <= 1'b1;
			idx_q         <= '0;
		end else if (step) begin
			if (is_last) begin
				list_valid_s1 <= 1'b0;
				idx_q         <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			list_s1 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_free)
			out_valid <= list_valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte     <= sel_byte ? list_s1.bytes[idx_q[1:0]] : 8'h00;
			byte_valid   <= sel_byte;
			status_valid <= !sel_byte;
			status       <= sel_byte ? ST_OK : list_s1.stat;
			run_last     <= is_last;
		end
	end

endmodule
